@@ src/txcon_pkg.sv @@
package txcon_pkg;

  // Register map: index of each configuration register (byte address is 4 * index).
  localparam logic [2:0] REG_PITCH_WORDS  = 3'd0;
  localparam logic [2:0] REG_TEXT_COLUMNS = 3'd1;
  localparam logic [2:0] REG_TEXT_ROWS    = 3'd2;
  localparam logic [2:0] REG_FG_COLOUR    = 3'd3;
  localparam logic [2:0] REG_BG_COLOUR    = 3'd4;

  // Configuration reset values.
  localparam logic [14:0] PITCH_RESET   = 15'd1024;
  localparam logic [9:0]  COLUMNS_RESET = 10'd128;
  localparam logic [8:0]  ROWS_RESET    = 9'd48;
  localparam logic [31:0] FG_RESET      = 32'hffa8a8a8;
  localparam logic [31:0] BG_RESET      = 32'h00000000;

  // Geometry limits of the cursor.
  localparam logic [9:0] MAX_COLUMNS = 10'd512;
  localparam logic [8:0] MAX_ROWS    = 9'd256;

  // Input function codes and the newline character.
  localparam logic       FUNC_FONT_WRITE = 1'b0;
  localparam logic       FUNC_PUT_CHAR   = 1'b1;
  localparam logic [7:0] NEWLINE_CODE    = 8'd10;

  localparam int unsigned PIXEL_ADDR_W = 26;

  typedef struct packed {
    logic        func;
    logic [11:0] font_index;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_ADDR_W-1:0] pixel_addr;
    logic [31:0]             left_colour;
    logic [31:0]             right_colour;
    logic                    last;
  } out_item_t;

endpackage

@@ src/text_console_glyph_renderer_unit.sv @@
// Text console renderer with a bitmap font store, eight pixels per glyph line.
// Input channel (in_valid_i / in_ready_o / in_item_i): func 0 writes one font
// byte, func 1 puts one character. A newline moves the cursor to column 0 of
// the next row. Any other character is drawn as GLYPH_LINES lines of four
// pixel pairs, one output transfer per pair, top line first, left pair first;
// the final pair carries last.
// Output channel (out_valid_o / out_ready_i / out_item_o): a word address and
// the colours of the two pixels at that address and the next one.
// A font write or newline is done in its transfer and leaves the input ready.
// A drawn character passes through the transfer, the set-up states ST_PREP
// (row times glyph height) and ST_BASE (that times the line pitch in the
// multiplier), then ST_EMIT, one pair per cycle while the receiver does not
// stall, while the next glyph line is prefetched. The first pair enters the
// output register from ST_EMIT, after ST_PREP and ST_BASE. The input is ready
// again once the last pair is in the output register, so the next item
// overlaps that final transfer. A stalled receiver holds the output register
// and the sequencer waits.
// Reset clears the cursor to the top left and loads the default geometry and
// colours; the font store is not cleared and must be written before use.
// Configuration goes through the APB port, one register per 32-bit word.
module text_console_glyph_renderer_unit #(
  parameter int unsigned GLYPH_LINES = 16,
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item input channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  txcon_pkg::in_item_t   in_item_i,
  // Result output channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output txcon_pkg::out_item_t  out_item_o,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned FONT_SIZE = GLYPH_LINES * GLYPH_COUNT;
  localparam int unsigned AW        = $clog2(FONT_SIZE);
  localparam int unsigned LW        = $clog2(GLYPH_LINES);
  localparam int unsigned RLW       = 8 + LW;
  localparam int unsigned PW        = RLW + 15;
  localparam int unsigned AdW       = txcon_pkg::PIXEL_ADDR_W;

  localparam logic [AW-1:0]  GLYPH_LINES_A = AW'(GLYPH_LINES);
  localparam logic [RLW-1:0] GLYPH_LINES_R = RLW'(GLYPH_LINES);
  localparam logic [8:0]     GLYPH_COUNT_C = 9'(GLYPH_COUNT);
  localparam logic [LW-1:0]  LAST_LINE     = LW'(GLYPH_LINES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_BASE,
    ST_EMIT
  } state_e;

  // Configuration registers.
  logic [14:0] pitch_q;
  logic [9:0]  columns_q;
  logic [8:0]  rows_q;
  logic [31:0] fg_q;
  logic [31:0] bg_q;

  // Sequencer and datapath registers.
  state_e                state_q;
  logic [8:0]            col_q;
  logic [7:0]            row_q;
  logic [AW-1:0]         font_rd_addr_q;
  logic [7:0]            font_rdata_q;
  logic [7:0]            bits_q;
  logic [RLW-1:0]        rowline_q;
  logic [AdW-1:0]        line_base_q;
  logic [LW-1:0]         line_q;
  logic [1:0]            pair_q;
  logic                  out_valid_q;
  txcon_pkg::out_item_t  out_item_q;

  logic [7:0] font_mem [FONT_SIZE];

  logic                 cfg_write;
  logic                 in_fire;
  logic                 font_we;
  logic                 is_newline;
  logic [9:0]           eff_cols;
  logic [8:0]           eff_rows;
  logic                 col_outside;
  logic                 col_at_end;
  logic [7:0]           next_row;
  logic [7:0]           glyph;
  logic [AW-1:0]        glyph_base;
  logic [PW-1:0]        product;
  logic                 out_load;
  logic                 pair_end;
  logic                 glyph_end;
  txcon_pkg::out_item_t pair_item;

  // Configuration write and read decode.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[4:2])
      txcon_pkg::REG_PITCH_WORDS:  prdata = {17'd0, pitch_q};
      txcon_pkg::REG_TEXT_COLUMNS: prdata = {22'd0, columns_q};
      txcon_pkg::REG_TEXT_ROWS:    prdata = {23'd0, rows_q};
      txcon_pkg::REG_FG_COLOUR:    prdata = fg_q;
      txcon_pkg::REG_BG_COLOUR:    prdata = bg_q;
      default:                     prdata = 32'd0;
    endcase
  end

  // Effective screen geometry and cursor advance.
  always_comb begin
    if (columns_q == 10'd0) begin
      eff_cols = 10'd1;
    end else if (columns_q > txcon_pkg::MAX_COLUMNS) begin
      eff_cols = txcon_pkg::MAX_COLUMNS;
    end else begin
      eff_cols = columns_q;
    end
    if (rows_q == 9'd0) begin
      eff_rows = 9'd1;
    end else if (rows_q > txcon_pkg::MAX_ROWS) begin
      eff_rows = txcon_pkg::MAX_ROWS;
    end else begin
      eff_rows = rows_q;
    end
    col_outside = {1'b0, col_q} >= eff_cols;
    col_at_end  = ({1'b0, col_q} + 10'd1) >= eff_cols;
    next_row    = (({1'b0, row_q} + 9'd1) >= eff_rows) ? 8'd0 : row_q + 8'd1;
  end

  // Input transfer decode and glyph location in the font store.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_newline = (in_item_i.char_code == txcon_pkg::NEWLINE_CODE);
  assign font_we    = in_fire && (in_item_i.func == txcon_pkg::FUNC_FONT_WRITE)
                      && (32'(in_item_i.font_index) < FONT_SIZE);

  always_comb begin
    if ({1'b0, in_item_i.char_code} >= GLYPH_COUNT_C) begin
      glyph = 8'({1'b0, in_item_i.char_code} - GLYPH_COUNT_C);
    end else begin
      glyph = in_item_i.char_code;
    end
    glyph_base = AW'(glyph) * GLYPH_LINES_A;
  end

  // Pitch multiplier: the text line offset (row times glyph height, formed in
  // ST_PREP) times the pitch.
  assign product = PW'(rowline_q) * PW'(pitch_q);

  // One pixel pair from the current glyph line.
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign pair_end  = (pair_q == 2'd3);
  assign glyph_end = pair_end && (line_q == LAST_LINE);

  always_comb begin
    pair_item.pixel_addr   = line_base_q + AdW'({pair_q, 1'b0});
    pair_item.left_colour  = bits_q[{~pair_q, 1'b1}] ? fg_q : bg_q;
    pair_item.right_colour = bits_q[{~pair_q, 1'b0}] ? fg_q : bg_q;
    pair_item.last         = glyph_end;
  end

  // Font memory: one write port for font transfers, one registered read port.
  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[AW'(in_item_i.font_index)] <= in_item_i.font_byte;
    end
    font_rdata_q <= font_mem[font_rd_addr_q];
  end

  // Sequencer, cursor, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q        <= txcon_pkg::PITCH_RESET;
      columns_q      <= txcon_pkg::COLUMNS_RESET;
      rows_q         <= txcon_pkg::ROWS_RESET;
      fg_q           <= txcon_pkg::FG_RESET;
      bg_q           <= txcon_pkg::BG_RESET;
      state_q        <= ST_IDLE;
      col_q          <= 9'd0;
      row_q          <= 8'd0;
      font_rd_addr_q <= '0;
      bits_q         <= 8'd0;
      rowline_q      <= '0;
      line_base_q    <= '0;
      line_q         <= '0;
      pair_q         <= 2'd0;
      out_valid_q    <= 1'b0;
      out_item_q     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[4:2])
          txcon_pkg::REG_PITCH_WORDS:  pitch_q   <= pwdata[14:0];
          txcon_pkg::REG_TEXT_COLUMNS: columns_q <= pwdata[9:0];
          txcon_pkg::REG_TEXT_ROWS:    rows_q    <= pwdata[8:0];
          txcon_pkg::REG_FG_COLOUR:    fg_q      <= pwdata;
          txcon_pkg::REG_BG_COLOUR:    bg_q      <= pwdata;
          default: ;
        endcase
      end

      // The output register empties when its transfer completes.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_item_q  <= pair_item;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_item_i.func == txcon_pkg::FUNC_PUT_CHAR)) begin
            if (is_newline) begin
              col_q <= 9'd0;
              row_q <= next_row;
            end else begin
              // A cursor left beyond the right edge wraps before drawing.
              if (col_outside) begin
                col_q <= 9'd0;
                row_q <= next_row;
              end
              font_rd_addr_q <= glyph_base;
              state_q        <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          rowline_q      <= RLW'(row_q) * GLYPH_LINES_R;
          state_q        <= ST_BASE;
        end
        ST_BASE: begin
          line_base_q    <= product[AdW-1:0] + AdW'({col_q, 3'b000});
          bits_q         <= font_rdata_q;
          font_rd_addr_q <= font_rd_addr_q + AW'(1);
          line_q         <= '0;
          pair_q         <= 2'd0;
          state_q        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            pair_q <= pair_q + 2'd1;
            if (pair_end) begin
              // Next glyph line: step down one pitch, take the prefetched byte.
              line_q         <= line_q + LW'(1);
              line_base_q    <= line_base_q + AdW'(pitch_q);
              bits_q         <= font_rdata_q;
              font_rd_addr_q <= font_rd_addr_q + AW'(1);
            end
            if (glyph_end) begin
              if (col_at_end) begin
                col_q <= 9'd0;
                row_q <= next_row;
              end else begin
                col_q <= col_q + 9'd1;
              end
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // A drawn character keeps the input closed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_item_i.func == txcon_pkg::FUNC_PUT_CHAR) && !is_newline)
      |=> !in_ready_o)
    else $error("input still ready after a character was taken");

  // New results appear only out of the emit phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("result produced outside the emit phase");

  // The font store is never written while a glyph is being drawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !font_we)
    else $error("font write during drawing");

  // Each glyph starts at the first pair of its top line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BASE) |=> (pair_q == 2'd0) && (line_q == '0))
    else $error("glyph did not start at its first pair");
`endif

endmodule
